>>> rtl/odo_pkg.sv
// Shared types and constants for the differential-drive odometry block.
// Used by odo_front, odo_fifo, odo_back and the top level.
package odo_pkg;

    localparam int TICK_W  = 16;
    localparam int SCALE_W = 32;
    localparam int TW_W    = 20;
    localparam int POS_W   = 32;
    localparam int TIME_W  = 32;
    localparam int HEAD_W  = 24;
    localparam int RATE_W  = 32;
    localparam int DIST_W  = 48;   // ticks * scale, signed Q.24 mm
    localparam int CFG_IDX_W = 3;

    localparam logic [POS_W-1:0]  START_X_RST = 32'd66560;   // 260 mm
    localparam logic [POS_W-1:0]  START_Y_RST = 32'd291840;  // 1140 mm
    localparam logic [HEAD_W-1:0] START_H_RST = 24'd0;
    localparam logic [TW_W-1:0]   TRACK_RST   = 20'd1;

    localparam logic [29:0] TURN_PER_RAD = 30'd683565276;  // 2^32 / 2pi
    localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;
    localparam logic [9:0]  MS_PER_S     = 10'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_SCALE    = 3'd0,
        REG_RIGHT_SCALE   = 3'd1,
        REG_TRACK_WIDTH   = 3'd2,
        REG_START_X       = 3'd3,
        REG_START_Y       = 3'd4,
        REG_START_HEADING = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic signed [DIST_W-1:0] dl;
        logic signed [DIST_W-1:0] dr;
        logic [TIME_W-1:0]        dt;
    } t_work;

    typedef struct packed {
        logic              load;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [HEAD_W-1:0] heading;
    } t_pose_cfg;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;  default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/odo_fifo.sv
// Two-entry queue of work requests between the front and back parts.
// Depends on odo_pkg (t_work).
module odo_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  odo_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output odo_pkg::t_work o_data
);

    odo_pkg::t_work r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("request popped from empty queue");

endmodule

>>> rtl/odo_front.sv
// Front part: takes input requests, keeps the previous timestamp, forms the
// scaled wheel distances and elapsed time. Depends on odo_pkg.
module odo_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [odo_pkg::TICK_W-1:0]     i_left_ticks,
    input  logic signed [odo_pkg::TICK_W-1:0]     i_right_ticks,
    input  logic [odo_pkg::TIME_W-1:0]            i_timestamp_ms,
    input  logic [odo_pkg::SCALE_W-1:0]           i_left_scale,
    input  logic [odo_pkg::SCALE_W-1:0]           i_right_scale,
    input  logic                                  i_full,
    output logic                                  o_push,
    output odo_pkg::t_work                        o_work
);

    logic                              r_vld;
    logic signed [odo_pkg::TICK_W-1:0] r_lt;
    logic signed [odo_pkg::TICK_W-1:0] r_rt;
    logic [odo_pkg::TIME_W-1:0]        r_dt;
    logic [odo_pkg::TIME_W-1:0]        r_prev;
    logic                              accept;
    logic signed [odo_pkg::DIST_W:0]   dl_full;
    logic signed [odo_pkg::DIST_W:0]   dr_full;

    assign o_push     = r_vld && !i_full;
    assign o_in_ready = !r_vld || !i_full;
    assign accept     = i_in_valid && o_in_ready;

    assign dl_full = r_lt * $signed({1'b0, i_left_scale});
    assign dr_full = r_rt * $signed({1'b0, i_right_scale});

    assign o_work.dl = dl_full[odo_pkg::DIST_W-1:0];
    assign o_work.dr = dr_full[odo_pkg::DIST_W-1:0];
    assign o_work.dt = r_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_prev <= '0;
        end else begin
            if (accept) begin
                r_vld  <= 1'b1;
                r_prev <= i_timestamp_ms;
            end else if (o_push) begin
                r_vld  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lt <= i_left_ticks;
            r_rt <= i_right_ticks;
            r_dt <= i_timestamp_ms - r_prev;   // wraps with the counter
        end
    end

endmodule

>>> rtl/odo_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by odo_back.
module odo_div #(
    parameter int NW = 48,
    parameter int DW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {r_rem, r_quo[NW-1]};
    assign fits   = (rem_sh >= {1'b0, r_den});
    assign o_busy = r_busy;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

endmodule

>>> rtl/odo_back.sv
// Back part: heading change divide, angle update, CORDIC sin/cos, position
// update and rate divides; holds the pose and the result register.
// Depends on odo_pkg and odo_div.
module odo_back #(
    parameter int CORDIC_STEPS = 24,
    parameter int ANGLE_BITS   = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  odo_pkg::t_work                    i_work,
    output logic                              o_pop,
    input  logic [odo_pkg::TW_W-1:0]          i_track_width,
    input  odo_pkg::t_pose_cfg                i_pose,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [odo_pkg::POS_W-1:0]  o_x_pos,
    output logic signed [odo_pkg::POS_W-1:0]  o_y_pos,
    output logic [odo_pkg::HEAD_W-1:0]        o_heading,
    output logic signed [odo_pkg::RATE_W-1:0] o_linear_speed,
    output logic signed [odo_pkg::RATE_W-1:0] o_turn_rate,
    output logic                              o_zero_interval
);

    localparam int AB  = ANGLE_BITS;
    localparam int SW  = $clog2(CORDIC_STEPS);
    localparam int QNW = 48;
    localparam int QDW = odo_pkg::TW_W;
    localparam int TNW = 58;
    localparam int SNW = 41;
    localparam int TDW = odo_pkg::TIME_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DIVQ, S_ANG1, S_ANG2, S_CINIT, S_CORD,
        S_FOLD, S_MULX, S_MULY, S_ADDY, S_WAIT
    } t_state;

    t_state                 r_state, n_state;
    logic signed [48:0]     r_diff;
    logic signed [47:0]     r_len;
    logic [47:0]            r_len_mag;
    logic [TDW-1:0]         r_dt;
    logic                   r_q_neg;
    logic [61:0]            r_plo;
    logic [15:0]            r_dqhi;
    logic [AB-1:0]          r_angle;
    logic signed [32:0]     r_z;
    logic signed [33:0]     r_x;
    logic signed [33:0]     r_y;
    logic [1:0]             r_quad;
    logic [SW-1:0]          r_step;
    logic signed [31:0]     r_c;
    logic signed [31:0]     r_s;
    logic [31:0]            r_prod;
    logic [31:0]            r_pos_x;
    logic [31:0]            r_pos_y;
    logic                   r_out_vld;
    logic [31:0]            r_o_x, r_o_y, r_o_spd, r_o_turn;
    logic [odo_pkg::HEAD_W-1:0] r_o_head;
    logic                   r_o_zero;

    // dividers
    logic           q_start, r_start;
    logic           q_busy, t_busy, s_busy;
    logic [QNW-1:0] q_num, q_quo;
    logic [QDW-1:0] q_den;
    logic [TNW-1:0] t_num, t_quo;
    logic [SNW-1:0] s_num, s_quo;

    logic signed [48:0] dq;
    logic [57:0]        t_prod;
    logic [57:0]        s_prod;
    logic [61:0]        plo;
    logic [45:0]        phi;
    logic [47:0]        dang;
    logic [31:0]        a32, a_off;
    logic signed [33:0] xs, ys;
    logic signed [32:0] at;
    logic signed [31:0] len8;
    logic signed [63:0] mprod;
    logic signed [31:0] msel;
    logic               out_free;
    logic               dt_zero;
    logic               len_nz, len_neg, dq_nz;

    function automatic logic [31:0] sat_rate(input logic neg, input logic [63:0] mag);
        logic [31:0] v;
        begin
            if (neg) begin
                v = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
            end else begin
                v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            end
            return v;
        end
    endfunction

    function automatic logic [31:0] zero_rate(input logic neg, input logic nz);
        logic [31:0] v;
        begin
            v = !nz ? 32'd0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
            return v;
        end
    endfunction

    assign q_start = (r_state == S_PREP);
    assign r_start = (r_state == S_ANG1);
    assign q_num   = r_diff[48] ? QNW'(49'sd0 - r_diff) : r_diff[QNW-1:0];
    assign q_den   = (i_track_width == '0) ? QDW'(1) : i_track_width;

    assign dq     = r_q_neg ? (49'sd0 - $signed({1'b0, q_quo})) : $signed({1'b0, q_quo});
    assign plo    = dq[31:0] * TURN_PER_RAD_62;
    assign t_prod = 58'(q_quo) * 58'(odo_pkg::MS_PER_S);
    assign s_prod = 58'(r_len_mag) * 58'(odo_pkg::MS_PER_S);
    assign t_num  = t_prod;
    assign s_num  = s_prod[56:16];
    assign phi    = r_dqhi * odo_pkg::TURN_PER_RAD;
    assign dang   = r_plo[47:0] + {phi[15:0], 32'd0};

    localparam logic [61:0] TURN_PER_RAD_62 = 62'(odo_pkg::TURN_PER_RAD);

    assign a32   = 32'(r_angle) << (32 - AB);
    assign a_off = a32 + 32'h2000_0000;

    assign xs = r_x >>> r_step;
    assign ys = r_y >>> r_step;
    assign at = $signed({1'b0, odo_pkg::atan_lut(5'(r_step))});

    assign len8  = r_len[47:16];
    assign msel  = (r_state == S_MULX) ? r_c : r_s;
    assign mprod = len8 * msel;

    assign out_free = !r_out_vld || i_out_ready;
    assign dt_zero  = (r_dt == '0);
    assign len_nz   = (r_len != '0);
    assign len_neg  = r_len[47];
    assign dq_nz    = (q_quo != '0);

    assign o_pop = (r_state == S_IDLE) && i_valid && !i_pose.load;

    odo_div #(.NW(QNW), .DW(QDW)) u_div_q (
        .i_clk, .i_rst_n, .i_start(q_start), .i_num(q_num), .i_den(q_den),
        .o_busy(q_busy), .o_quo(q_quo)
    );
    odo_div #(.NW(TNW), .DW(TDW)) u_div_turn (
        .i_clk, .i_rst_n, .i_start(r_start), .i_num(t_num), .i_den(r_dt),
        .o_busy(t_busy), .o_quo(t_quo)
    );
    odo_div #(.NW(SNW), .DW(TDW)) u_div_spd (
        .i_clk, .i_rst_n, .i_start(r_start), .i_num(s_num), .i_den(r_dt),
        .o_busy(s_busy), .o_quo(s_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (o_pop) n_state = S_PREP;
            S_PREP:  n_state = S_DIVQ;
            S_DIVQ:  if (!q_busy) n_state = S_ANG1;
            S_ANG1:  n_state = S_ANG2;
            S_ANG2:  n_state = S_CINIT;
            S_CINIT: n_state = S_CORD;
            S_CORD:  if (r_step == SW'(CORDIC_STEPS - 1)) n_state = S_FOLD;
            S_FOLD:  n_state = S_MULX;
            S_MULX:  n_state = S_MULY;
            S_MULY:  n_state = S_ADDY;
            S_ADDY:  n_state = S_WAIT;
            S_WAIT:  if (!t_busy && !s_busy && out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_pos_x   <= odo_pkg::START_X_RST;
            r_pos_y   <= odo_pkg::START_Y_RST;
            r_angle   <= AB'(32'(odo_pkg::START_H_RST));
        end else begin
            r_state <= n_state;
            if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_pose.load) begin
                r_pos_x <= i_pose.x;
                r_pos_y <= i_pose.y;
                r_angle <= AB'(32'(i_pose.heading));
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_diff <= 49'(i_work.dr) - 49'(i_work.dl);
                        r_len  <= 48'((49'(i_work.dl) + 49'(i_work.dr)) >>> 1);
                        r_dt   <= i_work.dt;
                    end
                end
                S_PREP: begin
                    r_q_neg   <= r_diff[48];
                    r_len_mag <= len_neg ? 48'(49'sd0 - 49'(r_len)) : r_len;
                end
                S_ANG1: begin
                    r_plo  <= plo;
                    r_dqhi <= dq[47:32];
                end
                S_ANG2: begin
                    r_angle <= r_angle + dang[47 -: AB];
                end
                S_CINIT: begin
                    r_quad <= a_off[31:30];
                    r_z    <= $signed({3'd0, a_off[29:0]}) - 33'sh0_2000_0000;
                    r_x    <= 34'(odo_pkg::CORDIC_GAIN);
                    r_y    <= '0;
                    r_step <= '0;
                end
                S_CORD: begin
                    if (!r_z[32]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + at;
                    end
                    r_step <= r_step + 1'b1;
                end
                S_FOLD: begin
                    case (r_quad)
                        2'd1: begin r_c <= 32'(-r_y); r_s <= 32'(r_x);  end
                        2'd2: begin r_c <= 32'(-r_x); r_s <= 32'(-r_y); end
                        2'd3: begin r_c <= 32'(r_y);  r_s <= 32'(-r_x); end
                        default: begin r_c <= 32'(r_x); r_s <= 32'(r_y); end
                    endcase
                end
                S_MULX: begin
                    r_prod <= mprod[61:30];
                end
                S_MULY: begin
                    r_pos_x <= r_pos_x + r_prod;
                    r_prod  <= mprod[61:30];
                end
                S_ADDY: begin
                    r_pos_y <= r_pos_y + r_prod;
                end
                S_WAIT: begin
                    if (n_state == S_IDLE) begin
                        r_out_vld <= 1'b1;
                        r_o_x     <= r_pos_x;
                        r_o_y     <= r_pos_y;
                        r_o_head  <= odo_pkg::HEAD_W'(32'(r_angle));
                        r_o_zero  <= dt_zero;
                        r_o_spd   <= dt_zero ? zero_rate(len_neg, len_nz)
                                             : sat_rate(len_neg, 64'(s_quo));
                        r_o_turn  <= dt_zero ? zero_rate(r_q_neg, dq_nz)
                                             : sat_rate(r_q_neg, 64'(t_quo));
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_x_pos         = r_o_x;
    assign o_y_pos         = r_o_y;
    assign o_heading       = r_o_head;
    assign o_linear_speed  = r_o_spd;
    assign o_turn_rate     = r_o_turn;
    assign o_zero_interval = r_o_zero;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && n_state == S_IDLE) |=> r_out_vld)
        else $error("request finished without a result");
    a_q_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANG1) |-> (!q_busy && !t_busy && !s_busy))
        else $error("divider still busy at angle update");

endmodule

>>> rtl/differential_drive_odometry.sv
// Dead-reckoning odometry for a two-wheel robot. One result per request.
// In the back part, a heading-change divide comes first, then the rate divides
// run alongside the CORDIC sin/cos and the position update. A two-entry queue
// lets the front take new requests while the back works. Start-register writes
// reload the pose; configuration is to be written by the user only while the
// block is idle, as the block itself does not enforce this.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 24,
    parameter int ANGLE_BITS   = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [odo_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [31:0]                           i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [odo_pkg::TICK_W-1:0]     i_left_ticks,
    input  logic signed [odo_pkg::TICK_W-1:0]     i_right_ticks,
    input  logic [odo_pkg::TIME_W-1:0]            i_timestamp_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [odo_pkg::POS_W-1:0]      o_x_pos,
    output logic signed [odo_pkg::POS_W-1:0]      o_y_pos,
    output logic [odo_pkg::HEAD_W-1:0]            o_heading,
    output logic signed [odo_pkg::RATE_W-1:0]     o_linear_speed,
    output logic signed [odo_pkg::RATE_W-1:0]     o_turn_rate,
    output logic                                  o_zero_interval
);

    logic [odo_pkg::SCALE_W-1:0] r_left_scale, r_right_scale;
    logic [odo_pkg::TW_W-1:0]    r_track;
    logic [odo_pkg::POS_W-1:0]   r_start_x, r_start_y;
    logic [odo_pkg::HEAD_W-1:0]  r_start_h;
    logic                        r_pose_load;
    logic                        cfg_wr;
    odo_pkg::t_pose_cfg          pose;
    odo_pkg::t_work              f_work, q_work;
    logic                        f_push, q_full, q_valid, q_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_scale  <= '0;
            r_right_scale <= '0;
            r_track       <= odo_pkg::TRACK_RST;
            r_start_x     <= odo_pkg::START_X_RST;
            r_start_y     <= odo_pkg::START_Y_RST;
            r_start_h     <= odo_pkg::START_H_RST;
            r_pose_load   <= 1'b0;
        end else begin
            r_pose_load <= 1'b0;
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    odo_pkg::REG_LEFT_SCALE:  r_left_scale  <= i_cfg_data;
                    odo_pkg::REG_RIGHT_SCALE: r_right_scale <= i_cfg_data;
                    odo_pkg::REG_TRACK_WIDTH: r_track <= i_cfg_data[odo_pkg::TW_W-1:0];
                    odo_pkg::REG_START_X: begin
                        r_start_x   <= i_cfg_data;
                        r_pose_load <= 1'b1;
                    end
                    odo_pkg::REG_START_Y: begin
                        r_start_y   <= i_cfg_data;
                        r_pose_load <= 1'b1;
                    end
                    odo_pkg::REG_START_HEADING: begin
                        r_start_h   <= i_cfg_data[odo_pkg::HEAD_W-1:0];
                        r_pose_load <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign pose.load    = r_pose_load;
    assign pose.x       = r_start_x;
    assign pose.y       = r_start_y;
    assign pose.heading = r_start_h;

    odo_front u_front (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_ready,
        .i_left_ticks, .i_right_ticks, .i_timestamp_ms,
        .i_left_scale(r_left_scale), .i_right_scale(r_right_scale),
        .i_full(q_full), .o_push(f_push), .o_work(f_work)
    );

    odo_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(f_push), .i_data(f_work), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_data(q_work)
    );

    odo_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .i_work(q_work), .o_pop(q_pop),
        .i_track_width(r_track), .i_pose(pose),
        .o_out_valid, .i_out_ready,
        .o_x_pos, .o_y_pos, .o_heading, .o_linear_speed, .o_turn_rate,
        .o_zero_interval
    );

endmodule

>>> verif/differential_drive_odometry_tb.sv
// Self-checking testbench for differential_drive_odometry: directed table, then random phases.
// Expected results: an in-file predictor, or the typed table rows; depends on rtl/odo_pkg.sv.
module differential_drive_odometry_tb;
    import odo_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;  // unmapped index, ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int   IDLE_PCT   = 23;
    localparam int   STALL_MAX  = 4000;   // cycles with no request moving
    localparam int   SETTLE     = 200;
    localparam int   PHASES     = 10;
    localparam int   PHASE_LEN  = 188;
    localparam logic [63:0] RAD_TO_TURN = 64'd683565276;

    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic [HEAD_W-1:0]        hdg;
        logic signed [RATE_W-1:0] speed;
        logic signed [RATE_W-1:0] rate;
        logic                     zero_dt;
    } pose_t;

    typedef struct {
        int                       group;
        logic signed [TICK_W-1:0] lt;
        logic signed [TICK_W-1:0] rt;
        logic [TIME_W-1:0]        ts;
        bit                       typed;
        pose_t                    res;
    } step_row_t;

    logic                       i_clk, i_rst_n;
    logic                       i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [31:0]                i_cfg_data;
    logic                       i_in_valid, o_in_ready;
    logic signed [TICK_W-1:0]   i_left_ticks, i_right_ticks;
    logic [TIME_W-1:0]          i_timestamp_ms;
    logic                       o_out_valid, i_out_ready;
    logic signed [POS_W-1:0]    o_x_pos, o_y_pos;
    logic [HEAD_W-1:0]          o_heading;
    logic signed [RATE_W-1:0]   o_linear_speed, o_turn_rate;
    logic                       o_zero_interval;

    differential_drive_odometry dut (.*);

    // predictor state
    logic [31:0]       m_lscale, m_rscale, m_sx, m_sy;
    logic [TW_W-1:0]   m_track;
    logic [HEAD_W-1:0] m_sh, m_hdg;
    logic [POS_W-1:0]  m_x, m_y;
    logic [TIME_W-1:0] m_prev_ts;

    pose_t     pose_q[$];
    step_row_t rows[$];
    bit        failed = 0;
    bit        no_idle = 0;
    int        quiet_cycles = 0;
    logic [TIME_W-1:0] last_ts = 0;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rate_sat(input longint num, input longint den);
        longint q;
        if (den == 0)
            return num > 0 ? 32'h7FFFFFFF : (num < 0 ? 32'h80000000 : 32'h0);
        q = num / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    task automatic reload_pose();
        m_x = m_sx;
        m_y = m_sy;
        m_hdg = m_sh;
    endtask

    task automatic track_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        case (idx)
            REG_LEFT_SCALE:    m_lscale = d;
            REG_RIGHT_SCALE:   m_rscale = d;
            REG_TRACK_WIDTH:   m_track = d[TW_W-1:0];
            REG_START_X:       begin m_sx = d; reload_pose(); end
            REG_START_Y:       begin m_sy = d; reload_pose(); end
            REG_START_HEADING: begin m_sh = d[HEAD_W-1:0]; reload_pose(); end
            default: ;
        endcase
    endtask

    task automatic advance_pose(input logic signed [TICK_W-1:0] lt,
                                input logic signed [TICK_W-1:0] rt,
                                input logic [TIME_W-1:0] ts, output pose_t r);
        longint dl, dr, tw, dq, len, len8, cx, sy, zz, xs, ys, tmp;
        logic [63:0] dang;
        logic [31:0] sh, dt;
        logic [1:0]  quad;
        dl = longint'(lt) * longint'(m_lscale);
        dr = longint'(rt) * longint'(m_rscale);
        tw = (m_track == 0) ? 1 : longint'(m_track);
        dq = (dr - dl) / tw;
        len = (dl + dr) >>> 1;
        len8 = len >>> 16;
        dang = (64'(dq) * RAD_TO_TURN) >> (48 - HEAD_W);
        dt = ts - m_prev_ts;
        m_prev_ts = ts;
        m_hdg = m_hdg + dang[HEAD_W-1:0];
        // CORDIC over the folded quadrant
        sh = {m_hdg, 8'h00} + 32'h20000000;
        quad = sh[31:30];
        zz = longint'({2'b00, sh[29:0]}) - 64'sd536870912;
        cx = longint'(CORDIC_GAIN);
        sy = 0;
        for (int i = 0; i < 24; i++) begin
            xs = cx >>> i;
            ys = sy >>> i;
            if (zz >= 0) begin
                cx -= ys; sy += xs; zz -= longint'(ATAN_TURN[i]);
            end else begin
                cx += ys; sy -= xs; zz += longint'(ATAN_TURN[i]);
            end
        end
        case (quad)
            2'd1: begin tmp = cx; cx = -sy; sy = tmp; end
            2'd2: begin cx = -cx; sy = -sy; end
            2'd3: begin tmp = cx; cx = sy; sy = -tmp; end
            default: ;
        endcase
        tmp = (len8 * cx) >>> 30;
        m_x = m_x + tmp[31:0];
        tmp = (len8 * sy) >>> 30;
        m_y = m_y + tmp[31:0];
        r.x = m_x;
        r.y = m_y;
        r.hdg = m_hdg;
        r.speed = rate_sat(len * 1000, longint'(dt) * 65536);
        r.rate = rate_sat(dq * 1000, longint'(dt));
        r.zero_dt = (dt == 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        track_reg_write(idx, d);
    endtask

    task automatic send_step(input logic signed [TICK_W-1:0] lt,
                             input logic signed [TICK_W-1:0] rt,
                             input logic [TIME_W-1:0] ts, input bit typed, input pose_t typed_res);
        pose_t p;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_left_ticks <= lt;
        i_right_ticks <= rt;
        i_timestamp_ms <= ts;
        do @(posedge i_clk); while (!o_in_ready);
        advance_pose(lt, rt, ts, p);
        pose_q.push_back(typed ? typed_res : p);
        last_ts = ts;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [31:0] ls, input logic [31:0] rs, input logic [31:0] tw,
                             input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] shd);
        write_reg(REG_LEFT_SCALE, ls);
        write_reg(REG_RIGHT_SCALE, rs);
        write_reg(REG_TRACK_WIDTH, tw);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_START_HEADING, shd);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
    endtask

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2, 3: return $urandom_range(32'h04000000, 32'h00200000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_track();
        logic [31:0] hi;
        hi = $urandom & 32'hFFF00000;   // unused upper bits
        case ($urandom_range(7))
            0: return hi;
            1: return hi | 32'd1;
            2: return hi | 32'hFFFFF;
            3: return hi | ($urandom & 32'hFFFFF);
            default: return hi | $urandom_range(128000, 10000);
        endcase
    endfunction

    function automatic logic signed [TICK_W-1:0] pick_ticks();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return $urandom_range(400) - 200;
            6, 7: return $urandom;
            8: return 16'sh7FFF;
            default: return 16'sh8000;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time(input logic [TIME_W-1:0] prev);
        case ($urandom_range(19))
            0, 1: return prev;
            2: return $urandom;
            default: return prev + $urandom_range(40, 1);
        endcase
    endfunction

    function automatic pose_t mk(input logic [31:0] x, input logic [31:0] y, input logic [23:0] h,
                                 input logic [31:0] spd, input logic [31:0] rt, input logic z);
        pose_t p;
        p.x = x; p.y = y; p.hdg = h; p.speed = spd; p.rate = rt; p.zero_dt = z;
        return p;
    endfunction

    function automatic step_row_t row(input int g, input int lt, input int rt,
                                      input logic [31:0] ts);
        step_row_t r;
        r.group = g; r.lt = lt; r.rt = rt; r.ts = ts; r.typed = 0;
        r.res = mk(0, 0, 0, 0, 0, 0);
        return r;
    endfunction

    function automatic step_row_t row_exp(input int lt, input int rt, input logic [31:0] ts,
                                          input pose_t p);
        step_row_t r;
        r = row(0, lt, rt, ts);
        r.typed = 1;
        r.res = p;
        return r;
    endfunction

    // output side: random back-pressure and checking
    always @(posedge i_clk) begin
        pose_t e;
        if (o_out_valid && i_out_ready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: result with no request pending: x=%h y=%h", $time, o_x_pos, o_y_pos);
                failed = 1;
            end else begin
                e = pose_q.pop_front();
                if (o_x_pos !== e.x) begin
                    $display("%0t: x_pos expected %h got %h", $time, e.x, o_x_pos);
                    failed = 1;
                end
                if (o_y_pos !== e.y) begin
                    $display("%0t: y_pos expected %h got %h", $time, e.y, o_y_pos);
                    failed = 1;
                end
                if (o_heading !== e.hdg) begin
                    $display("%0t: heading expected %h got %h", $time, e.hdg, o_heading);
                    failed = 1;
                end
                if (o_linear_speed !== e.speed) begin
                    $display("%0t: linear_speed expected %h got %h", $time, e.speed,
                             o_linear_speed);
                    failed = 1;
                end
                if (o_turn_rate !== e.rate) begin
                    $display("%0t: turn_rate expected %h got %h", $time, e.rate, o_turn_rate);
                    failed = 1;
                end
                if (o_zero_interval !== e.zero_dt) begin
                    $display("%0t: zero_interval expected %b got %b", $time, e.zero_dt,
                             o_zero_interval);
                    failed = 1;
                end
            end
        end
        i_out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int g;
        logic [TIME_W-1:0] ts;
        i_rst_n <= 0;
        i_cfg_valid <= 0;
        i_cfg_index <= REG_LEFT_SCALE;
        i_cfg_data <= 0;
        i_in_valid <= 0;
        i_left_ticks <= 0;
        i_right_ticks <= 0;
        i_timestamp_ms <= 0;
        i_out_ready <= 0;
        m_lscale = 0; m_rscale = 0; m_track = TRACK_RST;
        m_sx = START_X_RST; m_sy = START_Y_RST; m_sh = START_H_RST;
        reload_pose();
        m_prev_ts = 0;

        // reset values: scales are zero, so the pose holds still
        rows.push_back(row_exp(0, 0, 0, mk(66560, 291840, 0, 0, 0, 1)));
        rows.push_back(row_exp(32767, -32768, 0, mk(66560, 291840, 0, 0, 0, 1)));
        rows.push_back(row_exp(-32768, 32767, 1000, mk(66560, 291840, 0, 0, 0, 0)));
        // 1 mm per tick, 200 mm track
        rows.push_back(row(1, 100, 100, 1100));
        rows.push_back(row(1, 100, 100, 1100));      // zero interval, positive saturation
        rows.push_back(row(1, -100, -100, 1100));    // zero interval, negative saturation
        rows.push_back(row(1, 0, 50, 1200));
        rows.push_back(row(1, 50, 0, 1300));
        rows.push_back(row(1, 32767, 32767, 1400));
        rows.push_back(row(1, -32768, -32768, 1500));
        rows.push_back(row(1, 1000, -1000, 1501));
        rows.push_back(row(1, 5, 5, 32'hFFFFFFF0));
        rows.push_back(row(1, 5, 5, 32'h10));        // timestamp wraps
        rows.push_back(row(1, 0, 0, 32'h10));        // zero interval, no motion
        // largest scales, unit track, start at the extremes
        rows.push_back(row(2, 32767, -32768, 32'h20));
        rows.push_back(row(2, -32768, 32767, 32'h20));
        rows.push_back(row(2, 32767, 32767, 32'h21));
        rows.push_back(row(2, -32768, -32768, 32'hFFFFFFFF));
        rows.push_back(row(2, 1, 0, 32'hFFFFFFFF));
        // zero track width behaves as one
        rows.push_back(row(3, 300, -300, 32'h40));
        rows.push_back(row(3, -7, 9, 32'h41));
        // widest track
        rows.push_back(row(4, 32767, -32768, 32'h50));
        rows.push_back(row(4, 12, 3000, 32'h51));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        g = 0;
        foreach (rows[k]) begin
            if (rows[k].group != g) begin
                drain();
                g = rows[k].group;
                case (g)
                    1: write_all(32'h01000000, 32'h01000000, 32'h0000C800, 0, 0, 0);
                    2: write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 32'h80000000,
                                 32'h7FFFFFFF, 32'hFFFFFFFF);
                    3: write_all(32'h00800000, 32'h02000000, 32'h0, 32'h100, 32'hFFFFFF00,
                                 32'h400000);
                    default: write_all(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFF, 0, 0, 32'hC00000);
                endcase
            end
            send_step(rows[k].lt, rows[k].rt, rows[k].ts, rows[k].typed, rows[k].res);
        end

        ts = last_ts;
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            if (ph % 3 == 2) begin
                // a single start register still reloads the whole pose
                case ($urandom_range(2))
                    0: write_reg(REG_START_X, $urandom);
                    1: write_reg(REG_START_Y, $urandom);
                    default: write_reg(REG_START_HEADING, $urandom);
                endcase
            end else begin
                write_all(pick_scale(), pick_scale(), pick_track(), $urandom, $urandom, $urandom);
            end
            no_idle = (ph == 5);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (ph == 3 && n == PHASE_LEN / 2)
                    drain();
                ts = pick_time(ts);
                send_step(pick_ticks(), pick_ticks(), ts, 0, mk(0, 0, 0, 0, 0, 0));
            end
            no_idle = 0;
        end
        drain();

        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/odo_pkg.sv
rtl/odo_fifo.sv
rtl/odo_front.sv
rtl/odo_div.sv
rtl/odo_back.sv
rtl/differential_drive_odometry.sv
verif/differential_drive_odometry_tb.sv
